// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file abss_checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check, disabled while reset is held.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

// File: src/abss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abss_pkg
// Types and codes of the A/B boot slot selector.
// ---------------------------------------------------------------------------
package abss_pkg;

    typedef enum logic [1:0] {
        OP_DECIDE  = 2'd0,
        OP_INSTALL = 2'd1,
        OP_CONFIRM = 2'd2,
        OP_LOAD    = 2'd3
    } t_op;

    localparam logic [1:0] CFG_RECORD_FORMAT = 2'd0;
    localparam logic [1:0] CFG_MAX_TRIES     = 2'd1;
    localparam logic [1:0] CFG_STREAK_LIMIT  = 2'd2;

    localparam logic [1:0] SLOT_0    = 2'd0;
    localparam logic [1:0] SLOT_1    = 2'd1;
    localparam logic [1:0] SLOT_NONE = 2'd3;

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_PENDING     = 3'd1;
    localparam logic [2:0] ST_CONFIRMED   = 3'd2;
    localparam logic [2:0] ST_FAILED      = 3'd3;
    localparam logic [2:0] ST_ROLLED_BACK = 3'd4;

    localparam logic [1:0] MODE_SAFE    = 2'd0;
    localparam logic [1:0] MODE_RUN     = 2'd1;
    localparam logic [1:0] MODE_SERVICE = 2'd2;

    localparam logic [7:0] RESET_RECORD_FORMAT = 8'd1;
    localparam logic [3:0] RESET_MAX_TRIES     = 4'd3;
    localparam logic [7:0] RESET_STREAK_LIMIT  = 8'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int REC_W       = 51;

    // Packed in storage layout: format in the low byte, min version on top.
    typedef struct packed {
        logic [31:0] minver;
        logic [2:0]  status;
        logic [3:0]  tries;
        logic [1:0]  pend;
        logic [1:0]  conf;
        logic [7:0]  fmt;
    } t_rec;

    typedef struct packed {
        logic [7:0] record_format;
        logic [3:0] max_tries;
        logic [7:0] streak_limit;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [1:0]  slot;
        logic        service;
        logic [7:0]  streak;
        logic        ok0;
        logic        ok1;
        logic [31:0] ver0;
        logic [31:0] ver1;
        logic [31:0] img_min;
        t_rec        rec;
        logic        ver1_gt_ver0;
    } t_item;

endpackage

// File: src/abss_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abss_front
// Input side: takes operations, decodes them and pre-compares the image
// versions before the item enters the queue.
// ---------------------------------------------------------------------------
module abss_front (
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_operation,
    input  logic [1:0]           i_slot,
    input  logic                 i_service_request,
    input  logic [7:0]           i_streak_in,
    input  logic                 i_slot0_ok,
    input  logic                 i_slot1_ok,
    input  logic [31:0]          i_slot0_version,
    input  logic [31:0]          i_slot1_version,
    input  logic [31:0]          i_image_min_version,
    input  logic [50:0]          i_record_in,
    input  logic                 i_q_full,
    output logic                 o_push,
    output abss_pkg::t_item      o_item
);
    import abss_pkg::*;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_item              = '0;
        o_item.op           = t_op'(i_operation);
        o_item.slot         = i_slot;
        o_item.service      = i_service_request;
        o_item.streak       = i_streak_in;
        o_item.ok0          = i_slot0_ok;
        o_item.ok1          = i_slot1_ok;
        o_item.ver0         = i_slot0_version;
        o_item.ver1         = i_slot1_version;
        o_item.img_min      = i_image_min_version;
        o_item.rec          = t_rec'(i_record_in);
        // fallback tie-break does not depend on the record, settle it here
        o_item.ver1_gt_ver0 = i_slot1_version > i_slot0_version;
    end

endmodule

// File: src/abss_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abss_queue
// Two-entry FIFO between the front and the back.
// ---------------------------------------------------------------------------
module abss_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  abss_pkg::t_item  i_item,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output abss_pkg::t_item  o_item
);
    import abss_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_item            r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: src/abss_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abss_back
// Execution side: holds the boot record, carries out decide, install,
// confirm and load, and registers the result.
// ---------------------------------------------------------------------------
module abss_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  abss_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  abss_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_boot_mode,
    output logic [1:0]       o_boot_slot,
    output logic             o_store_needed,
    output logic             o_changed,
    output logic [7:0]       o_streak_out,
    output logic [50:0]      o_record_out
);
    import abss_pkg::*;

    t_rec       r_rec;
    t_rec       n_rec;
    logic       r_out_valid;
    logic [1:0] r_mode;
    logic [1:0] r_slot;
    logic       r_store;
    logic       r_chg;
    logic [7:0] r_streak;

    logic [1:0] n_mode;
    logic [1:0] n_slot;
    logic       n_store;
    logic       n_chg;
    logic [7:0] n_streak;

    t_rec       dflt_rec;
    t_rec       w_rec;
    logic       sane;
    logic       use0;
    logic       use1;
    logic       use_p;
    logic       use_c;
    logic       cand0;
    logic       cand1;
    logic [1:0] best;
    logic       trial_run;
    logic       take;

    assign take  = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_pop = take;

    always_comb begin
        dflt_rec     = '0;
        dflt_rec.fmt = i_cfg.record_format;
        dflt_rec.conf = SLOT_NONE;
        dflt_rec.pend = SLOT_NONE;
    end

    assign sane = (r_rec.fmt == i_cfg.record_format)
               && (r_rec.conf != 2'd2) && (r_rec.pend != 2'd2)
               && ((r_rec.pend == SLOT_NONE) || (r_rec.pend != r_rec.conf))
               && (r_rec.tries <= i_cfg.max_tries)
               && (r_rec.status <= ST_ROLLED_BACK);

    // record that decide works on: an insane one is replaced first
    assign w_rec = sane ? r_rec : dflt_rec;

    assign use0  = i_item.ok0 && (i_item.ver0 >= w_rec.minver);
    assign use1  = i_item.ok1 && (i_item.ver1 >= w_rec.minver);
    assign use_p = ((w_rec.pend == SLOT_0) && use0) || ((w_rec.pend == SLOT_1) && use1);
    assign use_c = ((w_rec.conf == SLOT_0) && use0) || ((w_rec.conf == SLOT_1) && use1);
    assign cand0 = use0 && (w_rec.conf != SLOT_0);
    assign cand1 = use1 && (w_rec.conf != SLOT_1);

    always_comb begin
        priority if (cand1 && (!cand0 || i_item.ver1_gt_ver0)) begin
            best = SLOT_1;
        end else if (cand0) begin
            best = SLOT_0;
        end else begin
            best = SLOT_NONE;
        end
    end

    always_comb begin
        n_rec     = r_rec;
        n_mode    = MODE_SAFE;
        n_slot    = SLOT_NONE;
        n_store   = 1'b0;
        n_chg     = 1'b0;
        n_streak  = i_item.streak;
        trial_run = 1'b0;
        unique case (i_item.op)
            OP_DECIDE: begin
                n_rec   = w_rec;
                n_store = !sane;
                if (i_item.service) begin
                    n_mode = MODE_SERVICE;
                end else begin
                    if (w_rec.pend != SLOT_NONE) begin
                        n_store  = 1'b1;
                        n_streak = '0;
                        if (use_p && (w_rec.tries < i_cfg.max_tries)) begin
                            trial_run    = 1'b1;
                            n_rec.tries  = w_rec.tries + 4'd1;
                            n_rec.status = ST_PENDING;
                            n_mode       = MODE_RUN;
                            n_slot       = w_rec.pend;
                        end else begin
                            n_rec.status = use_p ? ST_ROLLED_BACK : ST_FAILED;
                            n_rec.pend   = SLOT_NONE;
                            n_rec.tries  = '0;
                        end
                    end
                    if (!trial_run) begin
                        priority if (n_streak >= i_cfg.streak_limit) begin
                            n_mode = MODE_SAFE;
                        end else if (use_c) begin
                            n_mode = MODE_RUN;
                            n_slot = w_rec.conf;
                        end else if (best != SLOT_NONE) begin
                            n_rec.status = (w_rec.conf == SLOT_NONE) ? ST_CONFIRMED
                                                                     : ST_ROLLED_BACK;
                            n_rec.conf   = best;
                            n_store      = 1'b1;
                            n_mode       = MODE_RUN;
                            n_slot       = best;
                        end else begin
                            n_mode = MODE_SAFE;
                        end
                    end
                end
            end
            OP_INSTALL: begin
                n_rec.pend   = i_item.slot;
                n_rec.tries  = '0;
                n_rec.status = ST_PENDING;
            end
            OP_CONFIRM: begin
                if ((i_item.slot != 2'd2) && (i_item.slot != SLOT_NONE)) begin
                    if (r_rec.pend == i_item.slot) begin
                        n_rec.pend   = SLOT_NONE;
                        n_rec.tries  = '0;
                        n_rec.conf   = i_item.slot;
                        n_rec.status = ST_CONFIRMED;
                        n_chg        = 1'b1;
                    end
                    if ((n_rec.conf == i_item.slot) && (i_item.img_min > r_rec.minver)) begin
                        n_rec.minver = i_item.img_min;
                        n_chg        = 1'b1;
                    end
                end
            end
            OP_LOAD: begin
                n_rec = i_item.rec;
            end
            default: begin
                n_rec = r_rec;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec       <= '{minver: '0, status: ST_IDLE, tries: '0, pend: SLOT_NONE,
                             conf: SLOT_NONE, fmt: RESET_RECORD_FORMAT};
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_rec       <= n_rec;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode   <= n_mode;
            r_slot   <= n_slot;
            r_store  <= n_store;
            r_chg    <= n_chg;
            r_streak <= n_streak;
        end
    end

    // the record only moves when a new result is loaded, so it doubles as output
    assign o_out_valid    = r_out_valid;
    assign o_boot_mode    = r_mode;
    assign o_boot_slot    = r_slot;
    assign o_store_needed = r_store;
    assign o_changed      = r_chg;
    assign o_streak_out   = r_streak;
    assign o_record_out   = REC_W'(r_rec);

endmodule

// File: src/ab_boot_slot_selector_core.sv
`timescale 1ns / 1ps
// An operation that is transferred in passes through the queue and then the
// back end result register before its result is offered. Throughput: one
// operation per cycle while i_out_stall is low; the back end updates its record
// register once per operation taken; the two-entry queue absorbs output stalls.
// Reset (synchronous, active low): config registers return to 1/3/3, the boot
// record to its default (no slots, zero tries, idle, min version 0), queue empty.
// ---------------------------------------------------------------------------
// ab_boot_slot_selector_core
// A/B boot slot selection with trial boots, rollback and anti-rollback.
// ---------------------------------------------------------------------------
module ab_boot_slot_selector_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_slot,
    input  logic        i_service_request,
    input  logic [7:0]  i_streak_in,
    input  logic        i_slot0_ok,
    input  logic        i_slot1_ok,
    input  logic [31:0] i_slot0_version,
    input  logic [31:0] i_slot1_version,
    input  logic [31:0] i_image_min_version,
    input  logic [50:0] i_record_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_boot_mode,
    output logic [1:0]  o_boot_slot,
    output logic        o_store_needed,
    output logic        o_changed,
    output logic [7:0]  o_streak_out,
    output logic [50:0] o_record_out
);
    import abss_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item q_item;
    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_format <= RESET_RECORD_FORMAT;
            r_cfg.max_tries     <= RESET_MAX_TRIES;
            r_cfg.streak_limit  <= RESET_STREAK_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RECORD_FORMAT: r_cfg.record_format <= i_cfg_wdata;
                CFG_MAX_TRIES:     r_cfg.max_tries     <= i_cfg_wdata[3:0];
                CFG_STREAK_LIMIT:  r_cfg.streak_limit  <= i_cfg_wdata;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    abss_front u_front (
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_operation         (i_operation),
        .i_slot              (i_slot),
        .i_service_request   (i_service_request),
        .i_streak_in         (i_streak_in),
        .i_slot0_ok          (i_slot0_ok),
        .i_slot1_ok          (i_slot1_ok),
        .i_slot0_version     (i_slot0_version),
        .i_slot1_version     (i_slot1_version),
        .i_image_min_version (i_image_min_version),
        .i_record_in         (i_record_in),
        .i_q_full            (q_full),
        .o_push              (push),
        .o_item              (front_item)
    );

    abss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    abss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_item         (q_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_boot_mode    (o_boot_mode),
        .o_boot_slot    (o_boot_slot),
        .o_store_needed (o_store_needed),
        .o_changed      (o_changed),
        .o_streak_out   (o_streak_out),
        .o_record_out   (o_record_out)
    );

endmodule

// File: src/abss_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abss_checker
// Port-level checks on the boot slot selector results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module abss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_boot_mode,
    input logic [1:0]  o_boot_slot,
    input logic        o_store_needed,
    input logic        o_changed,
    input logic [50:0] o_record_out
);
    import abss_pkg::*;

    `ASSERT_PROP(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_record_out) && $stable(o_boot_slot), "stalled result changed")
    `ASSERT_PROP(a_service_no_slot, i_clk, i_rst_n, o_out_valid && (o_boot_mode == MODE_SERVICE) |-> (o_boot_slot == SLOT_NONE), "service mode names a slot")
    `ASSERT_PROP(a_safe_no_slot, i_clk, i_rst_n, o_out_valid && (o_boot_mode == MODE_SAFE) |-> (o_boot_slot == SLOT_NONE), "safe mode names a slot")
    `ASSERT_PROP(a_run_has_slot, i_clk, i_rst_n, o_out_valid && (o_boot_mode == MODE_RUN) |-> (o_boot_slot == SLOT_0) || (o_boot_slot == SLOT_1), "run mode without a real slot")
    `ASSERT_NEVER(a_store_chg_excl, i_clk, i_rst_n, o_out_valid && o_store_needed && o_changed, "decide and confirm flags together")

endmodule

bind ab_boot_slot_selector_core abss_checker u_abss_checker (.*);
